// ----- rtl/fcf_pkg.sv -----
`timescale 1ns / 1ps
package fcf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int MASS_W    = 31;
   localparam int COEF_W    = 18;
   // normal force after the fraction shift
   localparam int N_W       = 2 * MASS_W - FRAC_BITS;
   localparam int N_LO_W    = N_W / 2;
   localparam int N_HI_W    = N_W - N_LO_W;
   localparam int NP_W      = COEF_W + N_HI_W;
   localparam int NSUM_W    = COEF_W + N_W;
   // friction limits (static and kinetic) after the fraction shift
   localparam int FR_W      = NSUM_W - FRAC_BITS;
   localparam int FK_LO_W   = FR_W / 2;
   localparam int FK_HI_W   = FR_W - FK_LO_W;
   localparam int KP_W      = FK_HI_W + DATA_W;
   localparam int SQ_W      = 2 * DATA_W;
   localparam int MAG_W     = DATA_W;
   localparam int NUM_W     = FR_W + MAG_W;
   localparam int ROOT_STEPS = SQ_W / 2;
   localparam int QUOT_STEPS = FR_W;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_y;
      logic [MASS_W-1:0]        mass;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_pos_y;
      logic signed [DATA_W-1:0] new_force_x;
      logic signed [DATA_W-1:0] new_force_y;
      logic signed [DATA_W-1:0] new_force_z;
      logic                     zero_velocity;
      logic                     in_contact;
   } rsp_type;

   // carried alongside the square root
   typedef struct packed {
      logic                     contact;
      logic                     fy_neg;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
      logic [FR_W-1:0]          max_static;
      logic [FR_W-1:0]          fk;
   } root_side_type;

   // carried alongside the divider
   typedef struct packed {
      logic                     contact;
      logic                     kinetic;
      logic                     stick;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
   } quot_side_type;

endpackage

// ----- rtl/fcf_root.sv -----
`timescale 1ns / 1ps
module fcf_root import fcf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_vld,
   input  logic [SQ_W-1:0]  in_rad,
   input  root_side_type    in_side,
   output logic             out_vld,
   output logic [MAG_W-1:0] out_root,
   output root_side_type    out_side
);

   localparam int REM_W = MAG_W + 4;

   logic [ROOT_STEPS-1:0] vld_ff, vld_in;
   logic [REM_W-1:0]      rem_ff  [ROOT_STEPS];
   logic [REM_W-1:0]      rem_in  [ROOT_STEPS];
   logic [MAG_W-1:0]      root_ff [ROOT_STEPS];
   logic [MAG_W-1:0]      root_in [ROOT_STEPS];
   logic [SQ_W-1:0]       rad_ff  [ROOT_STEPS];
   logic [SQ_W-1:0]       rad_in  [ROOT_STEPS];
   root_side_type         side_ff [ROOT_STEPS];
   root_side_type         side_in [ROOT_STEPS];

   // one result bit per stage, two radicand bits brought down each time
   always_comb begin
      logic             pv;
      logic [REM_W-1:0] pr;
      logic [MAG_W-1:0] pq;
      logic [SQ_W-1:0]  pd;
      root_side_type    ps;
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] t;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         if (k == 0) begin
            pv = in_vld;
            pr = '0;
            pq = '0;
            pd = in_rad;
            ps = in_side;
         end else begin
            pv = vld_ff[k-1];
            pr = rem_ff[k-1];
            pq = root_ff[k-1];
            pd = rad_ff[k-1];
            ps = side_ff[k-1];
         end
         r = {pr[REM_W-3:0], pd[SQ_W-1 -: 2]};
         t = {{(REM_W-MAG_W-2){1'b0}}, pq, 2'b01};
         if (r >= t) begin
            rem_in[k]  = r - t;
            root_in[k] = {pq[MAG_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = r;
            root_in[k] = {pq[MAG_W-2:0], 1'b0};
         end
         rad_in[k]  = {pd[SQ_W-3:0], 2'b00};
         side_in[k] = ps;
         vld_in[k]  = pv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < ROOT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_STEPS-1];
   assign out_root = root_ff[ROOT_STEPS-1];
   assign out_side = side_ff[ROOT_STEPS-1];

endmodule

// ----- rtl/fcf_quot.sv -----
`timescale 1ns / 1ps
module fcf_quot import fcf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_vld,
   input  logic [NUM_W-1:0] in_num_x,
   input  logic [NUM_W-1:0] in_num_z,
   input  logic [MAG_W-1:0] in_mag,
   input  quot_side_type    in_side,
   output logic             out_vld,
   output logic [FR_W-1:0]  out_quot_x,
   output logic [FR_W-1:0]  out_quot_z,
   output quot_side_type    out_side
);

   logic [QUOT_STEPS-1:0] vld_ff, vld_in;
   logic [MAG_W-1:0]      rem_ff  [QUOT_STEPS][2];
   logic [MAG_W-1:0]      rem_in  [QUOT_STEPS][2];
   logic [FR_W-1:0]       low_ff  [QUOT_STEPS][2];
   logic [FR_W-1:0]       low_in  [QUOT_STEPS][2];
   logic [FR_W-1:0]       quo_ff  [QUOT_STEPS][2];
   logic [FR_W-1:0]       quo_in  [QUOT_STEPS][2];
   logic [MAG_W-1:0]      mag_ff  [QUOT_STEPS];
   logic [MAG_W-1:0]      mag_in  [QUOT_STEPS];
   quot_side_type         side_ff [QUOT_STEPS];
   quot_side_type         side_in [QUOT_STEPS];

   // restoring division, both lanes share the divisor; quotient fits FR_W bits
   always_comb begin
      logic [MAG_W-1:0] prem;
      logic [FR_W-1:0]  plow;
      logic [FR_W-1:0]  pquo;
      logic [MAG_W-1:0] pmag;
      logic [MAG_W:0]   r2;
      for (int k = 0; k < QUOT_STEPS; k++) begin
         pmag       = (k == 0) ? in_mag : mag_ff[k-1];
         mag_in[k]  = pmag;
         side_in[k] = (k == 0) ? in_side : side_ff[k-1];
         vld_in[k]  = (k == 0) ? in_vld : vld_ff[k-1];
         for (int j = 0; j < 2; j++) begin
            if (k == 0) begin
               prem = (j == 0) ? in_num_x[NUM_W-1 -: MAG_W] : in_num_z[NUM_W-1 -: MAG_W];
               plow = (j == 0) ? in_num_x[FR_W-1:0] : in_num_z[FR_W-1:0];
               pquo = '0;
            end else begin
               prem = rem_ff[k-1][j];
               plow = low_ff[k-1][j];
               pquo = quo_ff[k-1][j];
            end
            r2 = {prem, plow[FR_W-1]};
            if (r2 >= {1'b0, pmag}) begin
               rem_in[k][j] = MAG_W'(r2 - {1'b0, pmag});
               quo_in[k][j] = {pquo[FR_W-2:0], 1'b1};
            end else begin
               rem_in[k][j] = r2[MAG_W-1:0];
               quo_in[k][j] = {pquo[FR_W-2:0], 1'b0};
            end
            low_in[k][j] = {plow[FR_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QUOT_STEPS; k++) begin
            mag_ff[k]  <= mag_in[k];
            side_ff[k] <= side_in[k];
            for (int j = 0; j < 2; j++) begin
               rem_ff[k][j] <= rem_in[k][j];
               low_ff[k][j] <= low_in[k][j];
               quo_ff[k][j] <= quo_in[k][j];
            end
         end
      end
   end

   assign out_vld    = vld_ff[QUOT_STEPS-1];
   assign out_quot_x = quo_ff[QUOT_STEPS-1][0];
   assign out_quot_z = quo_ff[QUOT_STEPS-1][1];
   assign out_side   = side_ff[QUOT_STEPS-1];

endmodule

// ----- rtl/floor_contact_friction.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      req_data (req_type)
// rsp       out        rsp_valid / rsp_stall      rsp_data (rsp_type)
// csr       in/out     psel penable pwrite pready paddr pwdata prdata
//
// one item per cycle while the output is not stalled; the square root yields one
// result bit per stage and the friction divider one quotient bit per stage
// the whole pipeline holds while a result sits stalled in the output register
// synchronous active-high reset clears valid bits and loads register defaults
module floor_contact_friction import fcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [2:0] REG_FLOOR   = 3'd0;
   localparam logic [2:0] REG_MARGIN  = 3'd1;
   localparam logic [2:0] REG_GRAVITY = 3'd2;
   localparam logic [2:0] REG_STATIC  = 3'd3;
   localparam logic [2:0] REG_KINETIC = 3'd4;

   localparam logic signed [DATA_W:0] LVL_MAX = (DATA_W+1)'(2147483647);
   localparam logic signed [49:0]     RES_MAX = 50'sd2147483647;
   localparam logic signed [49:0]     RES_MIN = -50'sd2147483648;

   // configuration registers
   logic signed [DATA_W-1:0] floor_ff;
   logic [MASS_W-1:0]        margin_ff, gravity_ff;
   logic [COEF_W-1:0]        static_ff, kinetic_ff;
   logic                     csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= '0;
         margin_ff  <= MASS_W'(6554);
         gravity_ff <= MASS_W'(642908);
         static_ff  <= COEF_W'(32768);
         kinetic_ff <= COEF_W'(19661);
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_FLOOR:   floor_ff   <= pwdata;
            REG_MARGIN:  margin_ff  <= pwdata[MASS_W-1:0];
            REG_GRAVITY: gravity_ff <= pwdata[MASS_W-1:0];
            REG_STATIC:  static_ff  <= pwdata[COEF_W-1:0];
            REG_KINETIC: kinetic_ff <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_FLOOR:   prdata = floor_ff;
         REG_MARGIN:  prdata = {1'b0, margin_ff};
         REG_GRAVITY: prdata = {1'b0, gravity_ff};
         REG_STATIC:  prdata = {{(32-COEF_W){1'b0}}, static_ff};
         REG_KINETIC: prdata = {{(32-COEF_W){1'b0}}, kinetic_ff};
         default:     prdata = '0;
      endcase
   end

   // global advance
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~adv;

   // stage 1: contact test, normal force product, squares
   logic signed [DATA_W:0]   level;
   logic                     contact_in;
   logic signed [DATA_W-1:0] pos_in;
   logic signed [SQ_W-1:0]   sqx_in, sqz_in;

   logic                     s1_vld_ff, s1_contact_ff, s1_fyneg_ff;
   logic signed [DATA_W-1:0] s1_pos_ff, s1_fx_ff, s1_fy_ff, s1_fz_ff;
   logic [2*MASS_W-1:0]      s1_ng_ff;
   logic [SQ_W-1:0]          s1_sqx_ff, s1_sqz_ff;

   always_comb begin
      level = $signed({floor_ff[DATA_W-1], floor_ff}) + $signed({2'b00, margin_ff});
      contact_in = $signed({req_data.pos_y[DATA_W-1], req_data.pos_y}) <= level;
      if (!contact_in) begin
         pos_in = req_data.pos_y;
      end else if (level > LVL_MAX) begin
         pos_in = LVL_MAX[DATA_W-1:0];
      end else begin
         pos_in = level[DATA_W-1:0];
      end
      sqx_in = req_data.force_x * req_data.force_x;
      sqz_in = req_data.force_z * req_data.force_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_contact_ff <= contact_in;
         s1_fyneg_ff   <= req_data.force_y[DATA_W-1];
         s1_pos_ff     <= pos_in;
         s1_fx_ff      <= req_data.force_x;
         s1_fy_ff      <= req_data.force_y;
         s1_fz_ff      <= req_data.force_z;
         s1_ng_ff      <= req_data.mass * gravity_ff;
         s1_sqx_ff     <= $unsigned(sqx_in);
         s1_sqz_ff     <= $unsigned(sqz_in);
      end
   end

   // stage 2: friction limit partial products, sum of squares
   logic [N_W-1:0] n_norm;
   assign n_norm = s1_ng_ff[FRAC_BITS +: N_W];

   logic                     s2_vld_ff, s2_contact_ff, s2_fyneg_ff;
   logic signed [DATA_W-1:0] s2_pos_ff, s2_fx_ff, s2_fy_ff, s2_fz_ff;
   logic [NP_W-1:0]          s2_ms_lo_ff, s2_ms_hi_ff, s2_fk_lo_ff, s2_fk_hi_ff;
   logic [SQ_W-1:0]          s2_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_contact_ff <= s1_contact_ff;
         s2_fyneg_ff   <= s1_fyneg_ff;
         s2_pos_ff     <= s1_pos_ff;
         s2_fx_ff      <= s1_fx_ff;
         s2_fy_ff      <= s1_fy_ff;
         s2_fz_ff      <= s1_fz_ff;
         s2_ms_lo_ff   <= NP_W'(static_ff * n_norm[N_LO_W-1:0]);
         s2_ms_hi_ff   <= NP_W'(static_ff * n_norm[N_W-1:N_LO_W]);
         s2_fk_lo_ff   <= NP_W'(kinetic_ff * n_norm[N_LO_W-1:0]);
         s2_fk_hi_ff   <= NP_W'(kinetic_ff * n_norm[N_W-1:N_LO_W]);
         s2_sq_ff      <= s1_sqx_ff + s1_sqz_ff;
      end
   end

   // square root of the horizontal force, limits ride along
   logic [NSUM_W-1:0] ms_sum, fk_sum;
   root_side_type     root_side;
   logic              root_vld;
   logic [MAG_W-1:0]  root_mag;
   root_side_type     root_out;

   always_comb begin
      ms_sum = {s2_ms_hi_ff, {N_LO_W{1'b0}}} + NSUM_W'(s2_ms_lo_ff);
      fk_sum = {s2_fk_hi_ff, {N_LO_W{1'b0}}} + NSUM_W'(s2_fk_lo_ff);
      root_side.contact    = s2_contact_ff;
      root_side.fy_neg     = s2_fyneg_ff;
      root_side.pos_y      = s2_pos_ff;
      root_side.force_x    = s2_fx_ff;
      root_side.force_y    = s2_fy_ff;
      root_side.force_z    = s2_fz_ff;
      root_side.max_static = ms_sum[FRAC_BITS +: FR_W];
      root_side.fk         = fk_sum[FRAC_BITS +: FR_W];
   end

   fcf_root u_root (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (s2_vld_ff),
      .in_rad   (s2_sq_ff),
      .in_side  (root_side),
      .out_vld  (root_vld),
      .out_root (root_mag),
      .out_side (root_out)
   );

   // stage 4: branch decision and kinetic numerator partials
   logic              slide;
   logic [DATA_W-1:0] afx, afz;

   logic              s4_vld_ff;
   quot_side_type     s4_side_ff;
   logic [MAG_W-1:0]  s4_mag_ff;
   logic [KP_W-1:0]   s4_xl_ff, s4_xh_ff, s4_zl_ff, s4_zh_ff;

   always_comb begin
      slide = {{(FR_W-MAG_W){1'b0}}, root_mag} > root_out.max_static;
      afx   = root_out.force_x[DATA_W-1] ? DATA_W'(-root_out.force_x) : root_out.force_x;
      afz   = root_out.force_z[DATA_W-1] ? DATA_W'(-root_out.force_z) : root_out.force_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= root_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff.contact <= root_out.contact;
         s4_side_ff.kinetic <= root_out.contact & root_out.fy_neg & slide;
         s4_side_ff.stick   <= root_out.contact & root_out.fy_neg & ~slide;
         s4_side_ff.pos_y   <= root_out.pos_y;
         s4_side_ff.force_x <= root_out.force_x;
         s4_side_ff.force_y <= root_out.force_y;
         s4_side_ff.force_z <= root_out.force_z;
         s4_mag_ff <= root_mag;
         s4_xl_ff  <= KP_W'(root_out.fk[FK_LO_W-1:0] * afx);
         s4_xh_ff  <= KP_W'(root_out.fk[FR_W-1:FK_LO_W] * afx);
         s4_zl_ff  <= KP_W'(root_out.fk[FK_LO_W-1:0] * afz);
         s4_zh_ff  <= KP_W'(root_out.fk[FR_W-1:FK_LO_W] * afz);
      end
   end

   // stage 5: full numerators
   logic              s5_vld_ff;
   quot_side_type     s5_side_ff;
   logic [MAG_W-1:0]  s5_mag_ff;
   logic [NUM_W-1:0]  s5_nx_ff, s5_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_side_ff <= s4_side_ff;
         s5_mag_ff  <= s4_mag_ff;
         s5_nx_ff   <= NUM_W'({s4_xh_ff, {FK_LO_W{1'b0}}}) + NUM_W'(s4_xl_ff);
         s5_nz_ff   <= NUM_W'({s4_zh_ff, {FK_LO_W{1'b0}}}) + NUM_W'(s4_zl_ff);
      end
   end

   // friction term per component: fk * |f| / |h|
   logic              quot_vld;
   logic [FR_W-1:0]   quot_x, quot_z;
   quot_side_type     quot_out;

   fcf_quot u_quot (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_vld     (s5_vld_ff),
      .in_num_x   (s5_nx_ff),
      .in_num_z   (s5_nz_ff),
      .in_mag     (s5_mag_ff),
      .in_side    (s5_side_ff),
      .out_vld    (quot_vld),
      .out_quot_x (quot_x),
      .out_quot_z (quot_z),
      .out_side   (quot_out)
   );

   // final: apply friction, saturate, select the case
   logic signed [49:0]       wx, wz;
   logic signed [DATA_W-1:0] kx, kz;

   always_comb begin
      if (quot_out.force_x[DATA_W-1]) begin
         wx = 50'(quot_out.force_x) + $signed(50'(quot_x));
      end else begin
         wx = 50'(quot_out.force_x) - $signed(50'(quot_x));
      end
      if (quot_out.force_z[DATA_W-1]) begin
         wz = 50'(quot_out.force_z) + $signed(50'(quot_z));
      end else begin
         wz = 50'(quot_out.force_z) - $signed(50'(quot_z));
      end
      if (wx > RES_MAX)      kx = RES_MAX[DATA_W-1:0];
      else if (wx < RES_MIN) kx = RES_MIN[DATA_W-1:0];
      else                   kx = wx[DATA_W-1:0];
      if (wz > RES_MAX)      kz = RES_MAX[DATA_W-1:0];
      else if (wz < RES_MIN) kz = RES_MIN[DATA_W-1:0];
      else                   kz = wz[DATA_W-1:0];

      rsp_in.new_pos_y     = quot_out.pos_y;
      rsp_in.in_contact    = quot_out.contact;
      rsp_in.zero_velocity = quot_out.stick;
      if (quot_out.stick) begin
         rsp_in.new_force_x = '0;
         rsp_in.new_force_y = '0;
         rsp_in.new_force_z = '0;
      end else if (quot_out.kinetic) begin
         rsp_in.new_force_x = kx;
         rsp_in.new_force_y = '0;
         rsp_in.new_force_z = kz;
      end else begin
         rsp_in.new_force_x = quot_out.force_x;
         rsp_in.new_force_y = quot_out.force_y;
         rsp_in.new_force_z = quot_out.force_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= quot_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_stick_needs_contact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_velocity |-> rsp_data.in_contact)
      else $error("zero_velocity without contact");

   a_stick_clears_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_velocity |->
         rsp_data.new_force_x == '0 && rsp_data.new_force_y == '0 &&
         rsp_data.new_force_z == '0)
      else $error("static friction left a force");

   a_hold_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(s1_vld_ff) && $stable(s5_vld_ff))
      else $error("pipeline moved during output stall");

   a_branch_excl: assert property (@(posedge clock) disable iff (reset)
      quot_vld |-> !(quot_out.kinetic && quot_out.stick))
      else $error("kinetic and static branch both set");
`endif

endmodule
